@@ src/fpst_pkg.sv @@
package fpst_pkg;

	// sizing
	localparam int MAX_POSITIONS = 1024;
	localparam int ADDR_W        = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int POS_W         = ADDR_W + 2;
	localparam int SIZE_W        = 11;
	localparam int INDEX_W       = 10;
	localparam int DATA_W        = 32;
	localparam int CMP_W         = (POS_W > SIZE_W) ? POS_W : SIZE_W;
	localparam int UPC_W         = 4;

	// action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_PREFIX = 2'd2;
	localparam logic [1:0] ACT_RANGE  = 2'd3;

	// microprogram entry points
	localparam logic [UPC_W-1:0] UPC_FETCH       = 4'd0;
	localparam logic [UPC_W-1:0] UPC_CLEAR       = 4'd1;
	localparam logic [UPC_W-1:0] UPC_ADD         = 4'd2;
	localparam logic [UPC_W-1:0] UPC_PREFIX      = 4'd3;
	localparam logic [UPC_W-1:0] UPC_RANGE_HI    = 4'd4;
	localparam logic [UPC_W-1:0] UPC_RANGE_LO    = 4'd5;
	localparam logic [UPC_W-1:0] UPC_RANGE_SUB   = 4'd6;
	localparam logic [UPC_W-1:0] UPC_FINISH      = 4'd7;
	localparam logic [UPC_W-1:0] UPC_RESET_CLEAR = 4'd8;

	typedef enum logic [2:0] {
		OP_FETCH,
		OP_CLEAR,
		OP_WALK_UP,
		OP_WALK_DN_ADD,
		OP_WALK_DN_SUB,
		OP_LOAD_LO,
		OP_FINISH
	} op_t;

	// condition under which a step repeats itself
	typedef enum logic [2:0] {
		C_NEVER,
		C_CLR_MORE,
		C_UP_ACTIVE,
		C_DN_ACTIVE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic       take;
		logic       err;
		logic [1:0] action;
		logic       clr_more;
		logic       up_active;
		logic       dn_active;
		logic       out_busy;
	} flags_t;

endpackage

@@ src/fpst_seq.sv @@
module fpst_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  fpst_pkg::flags_t flags,
	output fpst_pkg::ctrl_t  ctrl
);
	import fpst_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_next;
	logic             cond_hit;

	// control store
	function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
		ctrl_t w;
		w = '{op: OP_FETCH, cond: C_NEVER, target: UPC_FETCH};
		unique case (addr)
			UPC_FETCH:       w = '{op: OP_FETCH,       cond: C_NEVER,     target: UPC_FETCH};
			UPC_CLEAR:       w = '{op: OP_CLEAR,       cond: C_CLR_MORE,  target: UPC_FINISH};
			UPC_ADD:         w = '{op: OP_WALK_UP,     cond: C_UP_ACTIVE, target: UPC_FINISH};
			UPC_PREFIX:      w = '{op: OP_WALK_DN_ADD, cond: C_DN_ACTIVE, target: UPC_FINISH};
			UPC_RANGE_HI:    w = '{op: OP_WALK_DN_ADD, cond: C_DN_ACTIVE, target: UPC_RANGE_LO};
			UPC_RANGE_LO:    w = '{op: OP_LOAD_LO,     cond: C_NEVER,     target: UPC_RANGE_SUB};
			UPC_RANGE_SUB:   w = '{op: OP_WALK_DN_SUB, cond: C_DN_ACTIVE, target: UPC_FINISH};
			UPC_FINISH:      w = '{op: OP_FINISH,      cond: C_OUT_BUSY,  target: UPC_FETCH};
			UPC_RESET_CLEAR: w = '{op: OP_CLEAR,       cond: C_CLR_MORE,  target: UPC_FETCH};
			default:         w = '{op: OP_FETCH,       cond: C_NEVER,     target: UPC_FETCH};
		endcase
		return w;
	endfunction

	assign ctrl = ucode_rom(upc_q);

	// repeat condition
	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     cond_hit = 1'b0;
			C_CLR_MORE:  cond_hit = flags.clr_more;
			C_UP_ACTIVE: cond_hit = flags.up_active;
			C_DN_ACTIVE: cond_hit = flags.dn_active;
			C_OUT_BUSY:  cond_hit = flags.out_busy;
			default:     cond_hit = 1'b0;
		endcase
	end

	// next step: dispatch on fetch, else repeat or jump
	always_comb begin
		upc_next = upc_q;
		if (ctrl.op == OP_FETCH) begin
			if (flags.take) begin
				if (flags.err) begin
					upc_next = UPC_FINISH;
				end else begin
					unique case (flags.action)
						ACT_CLEAR:  upc_next = UPC_CLEAR;
						ACT_ADD:    upc_next = UPC_ADD;
						ACT_PREFIX: upc_next = UPC_PREFIX;
						ACT_RANGE:  upc_next = UPC_RANGE_HI;
						default:    upc_next = UPC_FINISH;
					endcase
				end
			end
		end else if (!cond_hit) begin
			upc_next = ctrl.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_RESET_CLEAR;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

@@ src/fpst_datapath.sv @@
module fpst_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpst_pkg::ctrl_t               ctrl,
	output fpst_pkg::flags_t              flags,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fpst_pkg::SIZE_W-1:0]   size_in_use,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [fpst_pkg::INDEX_W-1:0]  index,
	input  logic [fpst_pkg::INDEX_W-1:0]  index_high,
	input  logic signed [fpst_pkg::DATA_W-1:0] delta,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [fpst_pkg::DATA_W-1:0] sum,
	output logic                          error
);
	import fpst_pkg::*;

	logic [DATA_W-1:0]  mem [MAX_POSITIONS];

	logic [SIZE_W-1:0]  size_q;
	logic [POS_W-1:0]   pos_q;
	logic [INDEX_W-1:0] lo_q;
	logic [DATA_W-1:0]  delta_q;
	logic [DATA_W-1:0]  acc_q;
	logic               err_q;
	logic               pend_q;
	logic               pend_up_q;
	logic               pend_sub_q;
	logic [ADDR_W-1:0]  pend_addr_q;
	logic [DATA_W-1:0]  rdata_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  sum_q;
	logic               error_q;

	logic [CMP_W-1:0]   n_cmp;
	logic               lo_bad;
	logic               hi_bad;
	logic               err_in;
	logic               take;
	logic [POS_W-1:0]   low_bit;
	logic               up_active;
	logic               dn_active;
	logic               clr_more;
	logic               issue;
	logic [ADDR_W-1:0]  rd_addr;
	logic [POS_W-1:0]   pos_start;
	logic               out_busy;

	// active size and range checks
	assign n_cmp  = (CMP_W'(size_q) > CMP_W'(MAX_POSITIONS)) ? CMP_W'(MAX_POSITIONS)
		: CMP_W'(size_q);
	assign lo_bad = CMP_W'(index) >= n_cmp;
	assign hi_bad = CMP_W'(index_high) >= n_cmp;

	always_comb begin
		unique case (action)
			ACT_CLEAR: err_in = 1'b0;
			ACT_RANGE: err_in = lo_bad | hi_bad;
			default:   err_in = lo_bad;
		endcase
	end

	// first node of the walk
	always_comb begin
		unique case (action)
			ACT_CLEAR: pos_start = '0;
			ACT_RANGE: pos_start = POS_W'(CMP_W'(index_high) + CMP_W'(1));
			default:   pos_start = POS_W'(CMP_W'(index) + CMP_W'(1));
		endcase
	end

	// handshake
	assign in_stall  = (ctrl.op != OP_FETCH);
	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid_q && out_stall;

	// walk conditions
	assign low_bit   = pos_q & (~pos_q + POS_W'(1));
	assign up_active = CMP_W'(pos_q) <= n_cmp;
	assign dn_active = pos_q != '0;
	assign clr_more  = pos_q != POS_W'(MAX_POSITIONS - 1);
	assign rd_addr   = ADDR_W'(pos_q - POS_W'(1));
	assign issue     = ((ctrl.op == OP_WALK_UP) && up_active)
		|| (((ctrl.op == OP_WALK_DN_ADD) || (ctrl.op == OP_WALK_DN_SUB)) && dn_active);

	always_comb begin
		flags.take      = take;
		flags.err       = err_in;
		flags.action    = action;
		flags.clr_more  = clr_more;
		flags.up_active = up_active;
		flags.dn_active = dn_active;
		flags.out_busy  = out_busy;
	end

	// node store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_CLEAR) begin
			mem[pos_q[ADDR_W-1:0]] <= '0;
		end else if (pend_q && pend_up_q) begin
			mem[pend_addr_q] <= rdata_q + delta_q;
		end
		rdata_q <= mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= size_in_use;
		end
	end

	// walk position and outstanding read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= issue;
			unique case (ctrl.op)
				OP_FETCH: begin
					if (take) pos_q <= pos_start;
				end
				OP_CLEAR: begin
					pos_q <= pos_q + POS_W'(1);
				end
				OP_WALK_UP: begin
					if (up_active) pos_q <= pos_q + low_bit;
				end
				OP_WALK_DN_ADD, OP_WALK_DN_SUB: begin
					if (dn_active) pos_q <= pos_q - low_bit;
				end
				OP_LOAD_LO: begin
					pos_q <= POS_W'(CMP_W'(lo_q));
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	// item payload, accumulator and pending read kind
	always_ff @(posedge clk) begin
		pend_up_q   <= (ctrl.op == OP_WALK_UP);
		pend_sub_q  <= (ctrl.op == OP_WALK_DN_SUB);
		pend_addr_q <= rd_addr;
		if (take) begin
			lo_q    <= index;
			delta_q <= delta;
			err_q   <= err_in;
			acc_q   <= '0;
		end else if (pend_q && !pend_up_q) begin
			acc_q <= pend_sub_q ? (acc_q - rdata_q) : (acc_q + rdata_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_FINISH) && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_FINISH) && !out_busy) begin
			sum_q   <= err_q ? '0 : acc_q;
			error_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sum       = sum_q;
	assign error     = error_q;

endmodule

@@ src/fenwick_prefix_sum_table_core.sv @@
// Binary indexed tree of 32-bit wrapping sums over up to 1024 positions.
// Input channel (in_valid / in_stall): action, index, index_high, delta.
// An item transfers when in_valid is high and in_stall is low. Actions:
// clear, add delta at index, prefix sum 0..index, range sum index..index_high.
// Output channel (out_valid / out_stall): one result per item, sum and error.
// error is set, with sum zero, when an index is at or beyond the active size.
// Config channel (cfg_valid / cfg_ready, always ready): size_in_use, to be
// written only while the block is idle and followed by a clear.
// Timing is set by the microcode sequencer and the node memory, which takes
// one node read per cycle while an add, prefix or range walk is active; clear
// writes one node per cycle.
// The item is taken in the fetch step; in_stall is low only there.
// After reset the node memory is swept to zero while in_stall
// stays high; the size register resets to 1024.
// The result sits in an output register; if the receiver stalls, the block
// still works on the next item and holds at its finish step until the
// output register frees up.
module fenwick_prefix_sum_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpst_pkg::SIZE_W-1:0]        size_in_use,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic [fpst_pkg::INDEX_W-1:0]       index,
	input  logic [fpst_pkg::INDEX_W-1:0]       index_high,
	input  logic signed [fpst_pkg::DATA_W-1:0] delta,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fpst_pkg::DATA_W-1:0] sum,
	output logic                               error
);
	import fpst_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	// microcode sequencer
	fpst_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// node memory, walk registers and result register
	fpst_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.flags       (flags),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.size_in_use (size_in_use),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.index       (index),
		.index_high  (index_high),
		.delta       (delta),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sum         (sum),
		.error       (error)
	);

endmodule
